/* hw/rtl/ahte_pkg.sv */
// ----------------------------------------------------------------------------
// ahte_pkg
// Shared types, constants and helpers for the ASCII85 / hex text encoder.
// ----------------------------------------------------------------------------
package ahte_pkg;

  localparam logic [6:0]  A85_LINE    = 7'd72;
  localparam logic [6:0]  HEX_LINE    = 7'd36;
  localparam logic [7:0]  A85_OFFSET  = 8'd33;
  localparam logic [7:0]  A85_ZERO    = 8'd122;
  localparam logic [7:0]  NEWLINE     = 8'd10;
  localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
  localparam int          RECIP_SHIFT = 38;
  localparam int          NUM_DIGITS  = 5;
  localparam int          FIFO_DEPTH  = 4;

  typedef enum logic [1:0] {
    KIND_HEX,
    KIND_ZERO,
    KIND_DIGITS
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] word;
    logic [1:0]  nm1;
    logic        page;
  } job_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][7:0] chars;
    logic [2:0]                 count;
    logic                       hex;
    logic                       page;
  } pkt_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'd48 + {4'b0, v};
    end else begin
      c = 8'd87 + {4'b0, v};
    end
    return c;
  endfunction

endpackage

/* hw/rtl/ascii85_hex_text_encoder_core.sv */
// ----------------------------------------------------------------------------
// ascii85_hex_text_encoder_core
// Encodes raw bytes as ASCII85 or lower-case hex text with line breaks.
//
//   Channel   Handshake             Payload
//   input     push / full           data_byte_i, flush_group_i, page_start_i
//   result    empty / pop           out_char_o, last_o
//   config    psel/penable/pwrite   paddr, pwdata, prdata (mode at 0x0)
//
// A byte is taken every cycle while the job queue has room. Results leave one
// character per cycle from the output register while the reader pops: two or
// three characters per hex byte and one or two per zero group. Any other
// ASCII85 group takes a load and five digit steps on the divide-by-85 unit,
// whatever its length. Reset is asynchronous and leaves the block idle in hex
// mode. Either side may stall; the job queue lets the front run ahead of output.
// ----------------------------------------------------------------------------
module ascii85_hex_text_encoder_core import ahte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        flush_group_i,
  input  logic        page_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_MODE = 1'b0;

  logic mode_q, mode_d;
  logic cfg_write;
  logic job_push;
  job_t job_in;
  job_t job_out;
  logic fifo_full;
  logic fifo_empty;
  logic job_pop;
  pkt_t pkt;
  logic pkt_valid;
  logic pkt_take;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign mode_d    = (cfg_write && (paddr[2] == REG_MODE)) ? pwdata[0] : mode_q;
  assign prdata    = (paddr[2] == REG_MODE) ? {31'b0, mode_q} : 32'b0;
  assign full      = fifo_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  ahte_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .push_i        (push),
    .data_byte_i   (data_byte_i),
    .flush_group_i (flush_group_i),
    .page_start_i  (page_start_i),
    .fifo_full_i   (fifo_full),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  ahte_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  ahte_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_valid_i (~fifo_empty),
    .job_pop_o   (job_pop),
    .pkt_o       (pkt),
    .pkt_valid_o (pkt_valid),
    .pkt_take_i  (pkt_take)
  );

  ahte_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .pkt_i       (pkt),
    .pkt_valid_i (pkt_valid),
    .pkt_take_o  (pkt_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

  // A packet is only handed over while the conversion stage holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pkt_take |-> pkt_valid)
    else $error("packet taken while none is held");

  // A line break is never the final character of a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_char_o == NEWLINE)) |-> !last_o)
    else $error("line break marked as last character");

  // A job leaves the queue only when the queue holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> !fifo_empty)
    else $error("job popped from empty queue");

endmodule

/* hw/rtl/ahte_front.sv */
// ----------------------------------------------------------------------------
// ahte_front
// Accepts raw bytes, gathers ASCII85 groups and classifies encoding jobs.
// ----------------------------------------------------------------------------
module ahte_front import ahte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_i,
  input  logic       push_i,
  input  logic [7:0] data_byte_i,
  input  logic       flush_group_i,
  input  logic       page_start_i,
  input  logic       fifo_full_i,
  output logic       job_push_o,
  output job_t       job_o
);

  logic [23:0] group_q, group_d;
  logic [1:0]  fill_q, fill_d;
  logic        page_pend_q, page_pend_d;
  logic        accept;
  logic        closes;
  logic [31:0] acc;
  logic [31:0] padded;

  assign accept = push_i & ~fifo_full_i;
  assign acc    = {group_q, data_byte_i};
  assign closes = (fill_q == 2'd3) | flush_group_i;

  always_comb begin
    case (fill_q)
      2'd0:    padded = {acc[7:0], 24'b0};
      2'd1:    padded = {acc[15:0], 16'b0};
      2'd2:    padded = {acc[23:0], 8'b0};
      default: padded = acc;
    endcase
  end

  always_comb begin
    job_o.nm1  = fill_q;
    job_o.page = page_start_i | page_pend_q;
    if (!mode_i) begin
      job_o.kind = KIND_HEX;
      job_o.word = {24'b0, data_byte_i};
    end else begin
      job_o.kind = ((fill_q == 2'd3) && (acc == 32'b0)) ? KIND_ZERO : KIND_DIGITS;
      job_o.word = padded;
    end
  end

  assign job_push_o = accept & (~mode_i | closes);

  always_comb begin
    group_d     = group_q;
    fill_d      = fill_q;
    page_pend_d = page_pend_q;
    if (accept && mode_i) begin
      if (closes) begin
        group_d = 24'b0;
        fill_d  = 2'd0;
      end else begin
        group_d = acc[23:0];
        fill_d  = fill_q + 2'd1;
      end
    end
    if (job_push_o) begin
      page_pend_d = 1'b0;
    end else if (accept && page_start_i) begin
      page_pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q     <= 24'b0;
      fill_q      <= 2'd0;
      page_pend_q <= 1'b0;
    end else begin
      group_q     <= group_d;
      fill_q      <= fill_d;
      page_pend_q <= page_pend_d;
    end
  end

endmodule

/* hw/rtl/ahte_fifo.sv */
// ----------------------------------------------------------------------------
// ahte_fifo
// Short job queue between the front and the conversion stage.
// ----------------------------------------------------------------------------
module ahte_fifo import ahte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  job_t            mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* hw/rtl/ahte_conv.sv */
// ----------------------------------------------------------------------------
// ahte_conv
// Turns one job into a packet of characters; base-85 digits one per cycle.
// ----------------------------------------------------------------------------
module ahte_conv import ahte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t job_i,
  input  logic job_valid_i,
  output logic job_pop_o,
  output pkt_t pkt_o,
  output logic pkt_valid_o,
  input  logic pkt_take_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  step_q, step_d;
  pkt_t        pkt_q, pkt_d;
  logic        load;
  logic [63:0] prod;
  logic [25:0] quot;
  logic [6:0]  q_lo;
  logic [6:0]  q_times_85;
  logic [6:0]  rem;
  logic [2:0]  slot;

  assign load = job_valid_i &
                ((state_q == ST_IDLE) | ((state_q == ST_HOLD) & pkt_take_i));
  assign job_pop_o   = load;
  assign pkt_o       = pkt_q;
  assign pkt_valid_o = (state_q == ST_HOLD);

  assign prod       = {32'b0, word_q} * {32'b0, RECIP_85};
  assign quot       = prod[63:RECIP_SHIFT];
  assign q_lo       = quot[6:0];
  assign q_times_85 = q_lo + (q_lo << 2) + (q_lo << 4) + (q_lo << 6);
  assign rem        = word_q[6:0] - q_times_85;
  assign slot       = 3'(NUM_DIGITS - 1) - step_q;

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    step_d  = step_q;
    pkt_d   = pkt_q;
    if (load) begin
      pkt_d.page = job_i.page;
      case (job_i.kind)
        KIND_ZERO: begin
          pkt_d.chars[0] = A85_ZERO;
          pkt_d.count    = 3'd1;
          pkt_d.hex      = 1'b0;
          state_d        = ST_HOLD;
        end
        KIND_DIGITS: begin
          word_d      = job_i.word;
          step_d      = 3'd0;
          pkt_d.count = {1'b0, job_i.nm1} + 3'd2;
          pkt_d.hex   = 1'b0;
          state_d     = ST_CONV;
        end
        default: begin
          pkt_d.chars[0] = hex_char(job_i.word[7:4]);
          pkt_d.chars[1] = hex_char(job_i.word[3:0]);
          pkt_d.count    = 3'd2;
          pkt_d.hex      = 1'b1;
          state_d        = ST_HOLD;
        end
      endcase
    end else begin
      case (state_q)
        ST_CONV: begin
          pkt_d.chars[slot] = A85_OFFSET + {1'b0, rem};
          word_d            = {6'b0, quot};
          step_d            = step_q + 3'd1;
          if (step_q == 3'(NUM_DIGITS - 1)) begin
            state_d = ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (pkt_take_i) begin
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    pkt_q  <= pkt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

/* hw/rtl/ahte_emit.sv */
// ----------------------------------------------------------------------------
// ahte_emit
// Sends packet characters one per cycle while popped, breaking long lines.
// ----------------------------------------------------------------------------
module ahte_emit import ahte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_i,
  input  pkt_t       pkt_i,
  input  logic       pkt_valid_i,
  output logic       pkt_take_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_char_o,
  output logic       last_o
);

  pkt_t       pkt_q, pkt_d;
  logic       active_q, active_d;
  logic [2:0] idx_q, idx_d;
  logic       nl_done_q, nl_done_d;
  logic [6:0] lu_q, lu_d;
  logic       any_q, any_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;

  logic       can_out;
  logic       step;
  logic       unit_start;
  logic       need_nl;
  logic       is_last;
  logic       finishing;
  logic [6:0] limit;
  logic [7:0] lu_sum;
  logic [6:0] lu_next;

  assign can_out    = ~out_valid_q | pop_i;
  assign step       = active_q & can_out;
  assign unit_start = ~pkt_q.hex | (idx_q == 3'd0);
  assign need_nl    = unit_start & ~nl_done_q & any_q & (lu_q == 7'd0);
  assign is_last    = ((idx_q + 3'd1) == pkt_q.count);
  assign finishing  = step & ~need_nl & is_last;
  assign pkt_take_o = pkt_valid_i & (~active_q | finishing);

  assign limit   = mode_i ? A85_LINE : HEX_LINE;
  assign lu_sum  = {1'b0, lu_q} + 8'd1;
  assign lu_next = (lu_sum >= {1'b0, limit}) ? 7'd0 : lu_sum[6:0];

  assign empty_o    = ~out_valid_q;
  assign out_char_o = out_char_q;
  assign last_o     = out_last_q;

  always_comb begin
    pkt_d       = pkt_q;
    active_d    = active_q;
    idx_d       = idx_q;
    nl_done_d   = nl_done_q;
    lu_d        = lu_q;
    any_d       = any_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    if (step) begin
      out_valid_d = 1'b1;
      if (unit_start && !nl_done_q) begin
        lu_d  = lu_next;
        any_d = 1'b1;
      end
      if (need_nl) begin
        out_char_d = NEWLINE;
        out_last_d = 1'b0;
        nl_done_d  = 1'b1;
      end else begin
        out_char_d = pkt_q.chars[idx_q];
        out_last_d = is_last;
        nl_done_d  = 1'b0;
        idx_d      = idx_q + 3'd1;
      end
      if (finishing) begin
        active_d = 1'b0;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end

    if (pkt_take_o) begin
      pkt_d     = pkt_i;
      active_d  = 1'b1;
      idx_d     = 3'd0;
      nl_done_d = 1'b0;
      if (pkt_i.page) begin
        lu_d  = 7'd0;
        any_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q      <= pkt_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= 3'd0;
      nl_done_q   <= 1'b0;
      lu_q        <= 7'd0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      idx_q       <= idx_d;
      nl_done_q   <= nl_done_d;
      lu_q        <= lu_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* bench/ahte_char_checker.sv */
// ----------------------------------------------------------------------------
// ahte_char_checker
// Watches the byte, character and register channels of the text encoder.
// It keeps its own copy of the mode, the open ASCII85 group and the line
// position, turns every accepted byte into the characters it should cause,
// and compares each popped character with the oldest one still owed.
// ----------------------------------------------------------------------------
module ahte_char_checker import ahte_pkg::*; #(
  parameter logic [2:0] MODE_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  data_byte_i,
  input  logic        flush_group_i,
  input  logic        page_start_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  out_char_i,
  input  logic        last_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  localparam logic [7:0]  DIGIT_BASE  = 8'h30;
  localparam logic [7:0]  LETTER_BASE = 8'h61;
  localparam logic [31:0] A85_RADIX   = 32'd85;

  char_t      pending_chars[$];
  logic [7:0] step_chars[$];
  logic       a85_mode_q;
  logic [23:0] group_bytes_q;
  logic [1:0] group_fill_q;
  logic [6:0] line_units_q;
  logic       any_emitted_q;
  int         fails;

  assign fail_cnt_o = fails;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    fails++;
  endtask

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? DIGIT_BASE + {4'b0, v} : LETTER_BASE + {4'b0, v} - 8'd10;
  endfunction

  task automatic start_unit();
    int limit;
    limit = a85_mode_q ? int'(A85_LINE) : int'(HEX_LINE);
    if (any_emitted_q && line_units_q == 7'd0) begin
      step_chars.push_back(NEWLINE);
    end
    if (int'(line_units_q) + 1 >= limit) begin
      line_units_q = 7'd0;
    end else begin
      line_units_q = line_units_q + 7'd1;
    end
    any_emitted_q = 1'b1;
  endtask

  task automatic encode_group(input logic [31:0] word, input int nbytes);
    logic [7:0]  digits [0:4];
    logic [31:0] rest;
    logic [31:0] rem;
    rest = word;
    if (word == 32'd0 && nbytes == 4) begin
      start_unit();
      step_chars.push_back(A85_ZERO);
    end else begin
      for (int i = 0; i < 5; i++) begin
        rem = rest % A85_RADIX;
        digits[i] = A85_OFFSET + rem[7:0];
        rest = rest / A85_RADIX;
      end
      for (int i = 0; i <= nbytes; i++) begin
        start_unit();
        step_chars.push_back(digits[4 - i]);
      end
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fl, input logic pg);
    logic [31:0] acc;
    int          nbytes;
    char_t       c;
    step_chars.delete();
    if (pg) begin
      line_units_q = 7'd0;
      any_emitted_q = 1'b0;
    end
    if (!a85_mode_q) begin
      start_unit();
      step_chars.push_back(nibble_char(b[7:4]));
      step_chars.push_back(nibble_char(b[3:0]));
    end else begin
      nbytes = int'(group_fill_q) + 1;
      acc = {group_bytes_q, b};
      if (nbytes == 4 || fl) begin
        acc = acc << (8 * (4 - nbytes));
        encode_group(acc, nbytes);
        group_bytes_q = '0;
        group_fill_q = '0;
      end else begin
        group_bytes_q = acc[23:0];
        group_fill_q = nbytes[1:0];
      end
    end
    for (int i = 0; i < step_chars.size(); i++) begin
      c.ch = step_chars[i];
      c.last = (i == step_chars.size() - 1);
      pending_chars.push_back(c);
    end
  endtask

  task automatic check_char();
    char_t want;
    if (pending_chars.size() == 0) begin
      report("character with none owed", out_char_i, 8'h00);
    end else begin
      want = pending_chars.pop_front();
      if (out_char_i !== want.ch) begin
        report("out_char", out_char_i, want.ch);
      end
      if (last_i !== want.last) begin
        report("last", {7'd0, last_i}, {7'd0, want.last});
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a85_mode_q = 1'b0;
      group_bytes_q = '0;
      group_fill_q = '0;
      line_units_q = '0;
      any_emitted_q = 1'b0;
      pending_chars.delete();
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        check_char();
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == MODE_ADDR) begin
        a85_mode_q = pwdata_i[0];
      end
      if (push_i && !full_i) begin
        encode_byte(data_byte_i, flush_group_i, page_start_i);
      end
      pending_o <= pending_chars.size();
    end
  end

  initial begin
    fails = 0;
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the ASCII85 / hex text encoder with directed and random bytes in
// both modes, with random gaps on both sides and one long output stall, and
// lets the character checker judge every character that comes out.
// ----------------------------------------------------------------------------
module tb;
  import ahte_pkg::*;

  localparam logic [2:0]  MODE_ADDR         = 3'd0;
  localparam logic [31:0] MODE_HEX          = 32'd0;
  localparam logic [31:0] MODE_A85          = 32'd1;
  localparam int          IDLE_PCT          = 25;
  localparam int          HOLD_CYCLES       = 400;
  localparam int          STALL_LIMIT       = 4000;
  localparam int          CFG_SETTLE_CYCLES = 20;
  localparam int          DRAIN_CYCLES      = 40;
  localparam int          RANDOM_ITEMS      = 200;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        flush_group;
  logic        page_start;
  logic        empty;
  logic        pop;
  logic [7:0]  out_char;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_cnt;
  int pending;
  int sent_items;
  int holds_asked;
  int holds_done;
  int quiet_cycles;
  bit tx_steady;
  bit rx_steady;

  ascii85_hex_text_encoder_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte),
    .flush_group_i (flush_group),
    .page_start_i  (page_start),
    .empty         (empty),
    .pop           (pop),
    .out_char_o    (out_char),
    .last_o        (last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ahte_char_checker #(.MODE_ADDR(MODE_ADDR)) char_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push_i        (push),
    .full_i        (full),
    .data_byte_i   (data_byte),
    .flush_group_i (flush_group),
    .page_start_i  (page_start),
    .empty_i       (empty),
    .pop_i         (pop),
    .out_char_i    (out_char),
    .last_i        (last),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (psel && penable && pwrite && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    pop <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fl, input logic pg);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    flush_group <= fl;
    page_start <= pg;
    do @(posedge clk); while (full);
    sent_items++;
  endtask

  task automatic write_mode(input logic [31:0] value);
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (CFG_SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_random_group();
    int         len;
    bit         zeros;
    logic [7:0] b;
    logic       fl;
    len = ($urandom_range(99) < 60) ? 4 : $urandom_range(3, 1);
    zeros = ($urandom_range(99) < 15);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      if (zeros) begin
        b = 8'h00;
      end
      fl = ((i == len - 1) && (len < 4 || $urandom_range(9) == 0)) ||
           ($urandom_range(99) < 5);
      send_byte(b, fl, $urandom_range(99) < 1);
    end
  endtask

  initial begin
    int phase;
    int random_goal;
    int phase_goal;
    rst_n <= 1'b0;
    push <= 1'b0;
    data_byte <= 8'h00;
    flush_group <= 1'b0;
    page_start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sent_items = 0;
    holds_asked = 0;
    holds_done = 0;
    quiet_cycles = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(MODE_HEX);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b1, 1'b0);

    write_mode(MODE_A85);
    repeat (4) send_byte(8'h00, 1'b0, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'h03, 1'b1, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b1);
    send_byte(8'h56, 1'b0, 1'b0);
    send_byte(8'h78, 1'b0, 1'b0);
    send_byte(8'hAB, 1'b0, 1'b0);
    write_mode(MODE_HEX);
    send_byte(8'h3C, 1'b1, 1'b0);
    write_mode(MODE_A85);
    send_byte(8'hCD, 1'b0, 1'b0);
    send_byte(8'hEF, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);

    phase = 0;
    random_goal = sent_items + RANDOM_ITEMS;
    while (sent_items < random_goal) begin
      write_mode((phase % 2 == 0) ? MODE_HEX : MODE_A85);
      tx_steady = (phase == 2);
      rx_steady = (phase == 2);
      if (phase == 1) begin
        holds_asked <= holds_asked + 1;
      end
      phase_goal = sent_items + ((phase % 2 == 0) ? $urandom_range(50, 15)
                                                  : $urandom_range(70, 40));
      while (sent_items < phase_goal) begin
        send_random_group();
      end
      phase++;
    end

    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
